// ===== rtl/exit_event_validator_macros.svh =====
// Assertion macros for the exit event validator checker.
`ifndef EXIT_EVENT_VALIDATOR_MACROS_SVH
`define EXIT_EVENT_VALIDATOR_MACROS_SVH

// Clocked assertion, quiet while reset is high.
`define EEV_ASSERT(label, clk, rst, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Clocked assertion that also watches the reset cycles.
`define EEV_ASSERT_ALWAYS(label, clk, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== rtl/eev_pkg.sv =====
// Types and constants for the exit event validator.
`timescale 1ns / 1ps
`default_nettype none

package eev_pkg;

  localparam int TOKEN_W  = 64;
  localparam int HALF_W   = 32;
  localparam int ROT_BITS = 17;
  localparam int KIND_W   = 3;
  localparam int FAULT_W  = 3;
  localparam int CFG_IDX_W = 2;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_COOKIE     = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_VERSION    = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_EXIT_COUNT = 2'd2;

  // request types
  localparam logic REQ_CHECK = 1'b0;
  localparam logic REQ_WRITE = 1'b1;

  // exit kinds
  localparam logic [KIND_W-1:0] KIND_FAULT = 3'd0;
  localparam logic [KIND_W-1:0] KIND_NEXT  = 3'd1;
  localparam logic [KIND_W-1:0] KIND_CALL  = 3'd2;
  localparam logic [KIND_W-1:0] KIND_TAIL  = 3'd3;

  // result codes
  localparam logic [FAULT_W-1:0] FAULT_NONE        = 3'd0;
  localparam logic [FAULT_W-1:0] FAULT_BAD_VERSION = 3'd1;
  localparam logic [FAULT_W-1:0] FAULT_BAD_KIND    = 3'd2;
  localparam logic [FAULT_W-1:0] FAULT_BAD_TARGET  = 3'd3;
  localparam logic [FAULT_W-1:0] FAULT_BAD_SITE    = 3'd4;

  typedef struct packed {
    logic [HALF_W-1:0] site;
    logic [KIND_W-1:0] kind;
    logic [HALF_W-1:0] target_fragment;
    logic [HALF_W-1:0] target_function;
    logic [HALF_W-1:0] continuation;
  } entry_t;

  typedef struct packed {
    logic hit;
    logic target_ok;
  } match_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DONE
  } state_t;

endpackage

`default_nettype wire

// ===== rtl/eev_table.sv =====
// Allowed-exit table: one write port, one registered read port.
`timescale 1ns / 1ps
`default_nettype none

module eev_table #(
  parameter int MAX_EXITS = 16,
  parameter int IDX_W = 4
) (
  input  wire logic                clk,
  input  wire logic                wr_en,
  input  wire logic [IDX_W-1:0]    wr_addr,
  input  wire eev_pkg::entry_t     wr_entry,
  input  wire logic                rd_en,
  input  wire logic [IDX_W-1:0]    rd_addr,
  output eev_pkg::entry_t          rd_entry
);

  eev_pkg::entry_t mem [MAX_EXITS];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_entry;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_entry <= mem[rd_addr];
    end
  end

endmodule

`default_nettype wire

// ===== rtl/eev_match.sv =====
// Shared compare unit: one table entry against the decoded event.
`timescale 1ns / 1ps
`default_nettype none

module eev_match (
  input  wire eev_pkg::entry_t                 entry,
  input  wire logic [eev_pkg::KIND_W-1:0]      kind,
  input  wire logic [eev_pkg::HALF_W-1:0]      site,
  input  wire logic [eev_pkg::TOKEN_W-1:0]     target_dec,
  input  wire logic [eev_pkg::HALF_W-1:0]      cont_fragment,
  output eev_pkg::match_t                      result
);

  logic [eev_pkg::HALF_W-1:0] tgt_fragment;
  logic [eev_pkg::HALF_W-1:0] tgt_function;

  assign tgt_fragment = target_dec[eev_pkg::HALF_W-1:0];
  assign tgt_function = target_dec[eev_pkg::TOKEN_W-1:eev_pkg::HALF_W];

  always_comb begin
    result.hit = (entry.site == site) && (entry.kind == kind);
    case (kind)
      eev_pkg::KIND_NEXT: result.target_ok = (tgt_fragment == entry.target_fragment);
      eev_pkg::KIND_CALL: result.target_ok = (tgt_function == entry.target_function) &&
                                             (tgt_fragment == '0) &&
                                             (cont_fragment == entry.continuation);
      eev_pkg::KIND_TAIL: result.target_ok = (tgt_function == entry.target_function) &&
                                             (tgt_fragment == '0);
      default:            result.target_ok = 1'b1;  // plain kinds pass on any match
    endcase
  end

endmodule

`default_nettype wire

// ===== rtl/exit_event_validator.sv =====
// Exit event validator: checks exit events against a table of allowed exits.
// Input channel (in_valid / in_stall) carries one item: req_type 1 writes
// table entry entry_index, req_type 0 checks an exit event. Every item gives
// exactly one fault code on the output channel (out_valid / out_stall); a write
// gives 0. Registers (0 cookie, 1 expected_version, 2 exit_count) are set
// through cfg_wr_en / cfg_index / cfg_data; the user must set them only while
// the block is idle, as the block itself does not enforce it. A write item, or
// a check that fails on version or kind, moves from res to the output register
// once that is free. Any other check scans the table in order through a single
// registered read port, one entry per cycle into one shared compare unit; the
// first hit ends the scan, a miss reads all limit entries, limit being
// exit_count capped at MAX_EXITS. in_stall is high while an accepted item is in
// work and drops as its result is loaded into the output register, so a new
// item is taken only once the last result is there, and the next item is taken
// while a result still waits on a stalled receiver. While out_stall is high a
// shown result and out_valid hold. Reset empties the output, returns to idle
// and loads the register reset values; the table needs no clearing.
`timescale 1ns / 1ps
`default_nettype none

module exit_event_validator #(
  parameter int MAX_EXITS = 16
) (
  input  wire logic                            clk,
  input  wire logic                            rst,
  input  wire logic                            cfg_wr_en,
  input  wire logic [eev_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  wire logic [eev_pkg::TOKEN_W-1:0]     cfg_data,
  input  wire logic                            in_valid,
  output logic                                 in_stall,
  input  wire logic                            req_type,
  input  wire logic [3:0]                      entry_index,
  input  wire logic [31:0]                     event_version,
  input  wire logic [eev_pkg::KIND_W-1:0]      exit_kind,
  input  wire logic [31:0]                     site_id,
  input  wire logic [eev_pkg::TOKEN_W-1:0]     tgt_token,
  input  wire logic [eev_pkg::TOKEN_W-1:0]     cont_token,
  input  wire logic [31:0]                     entry_target_fragment,
  input  wire logic [31:0]                     entry_target_function,
  input  wire logic [31:0]                     entry_continuation_fragment,
  output logic                                 out_valid,
  input  wire logic                            out_stall,
  output logic [eev_pkg::FAULT_W-1:0]          fault
);

  localparam int IDX_W  = (MAX_EXITS > 1) ? $clog2(MAX_EXITS) : 1;
  localparam int CNT_RAW = $clog2(MAX_EXITS + 1);
  localparam int CNT_W  = (CNT_RAW > 5) ? CNT_RAW : 5;

  // configuration
  logic [eev_pkg::TOKEN_W-1:0] cookie;
  logic [31:0]                 expected_version;
  logic [4:0]                  exit_count;

  // latched event
  logic [eev_pkg::KIND_W-1:0]  ev_kind;
  logic [31:0]                 ev_site;
  logic [eev_pkg::TOKEN_W-1:0] ev_target;
  logic [eev_pkg::HALF_W-1:0]  ev_cont;
  logic [CNT_W-1:0]            limit;

  // scan control
  eev_pkg::state_t             state, state_next;
  logic [CNT_W-1:0]            ptr;
  logic                        rd_vld;
  logic                        issue;
  logic                        rd_en;
  logic                        scan_done;
  logic [eev_pkg::FAULT_W-1:0] res, res_next, scan_res;
  logic                        out_load;

  logic                        in_acc;
  logic                        wr_ok;
  logic [CNT_W-1:0]            wr_idx_ext;
  logic [CNT_W-1:0]            count_ext;
  logic [eev_pkg::TOKEN_W-1:0] tgt_dec;
  logic [eev_pkg::TOKEN_W-1:0] cont_dec;
  eev_pkg::entry_t             wr_entry;
  eev_pkg::entry_t             rd_entry;
  eev_pkg::match_t             m;

  assign in_stall = (state != eev_pkg::ST_IDLE);
  assign in_acc   = in_valid && !in_stall;
  assign out_load = (state == eev_pkg::ST_DONE) && (!out_valid || !out_stall);

  assign wr_idx_ext = CNT_W'(entry_index);
  assign wr_ok      = wr_idx_ext < CNT_W'(MAX_EXITS);
  assign count_ext  = CNT_W'(exit_count);

  // rotate right, then strip the cookie
  assign tgt_dec  = {tgt_token[eev_pkg::ROT_BITS-1:0],
                     tgt_token[eev_pkg::TOKEN_W-1:eev_pkg::ROT_BITS]} ^ cookie;
  assign cont_dec = {cont_token[eev_pkg::ROT_BITS-1:0],
                     cont_token[eev_pkg::TOKEN_W-1:eev_pkg::ROT_BITS]} ^ cookie;

  always_comb begin
    wr_entry.site            = site_id;
    wr_entry.kind            = exit_kind;
    wr_entry.target_fragment = entry_target_fragment;
    wr_entry.target_function = entry_target_function;
    wr_entry.continuation    = entry_continuation_fragment;
  end

  eev_table #(
    .MAX_EXITS (MAX_EXITS),
    .IDX_W     (IDX_W)
  ) u_table (
    .clk      (clk),
    .wr_en    (in_acc && (req_type == eev_pkg::REQ_WRITE) && wr_ok),
    .wr_addr  (wr_idx_ext[IDX_W-1:0]),
    .wr_entry (wr_entry),
    .rd_en    (rd_en),
    .rd_addr  (ptr[IDX_W-1:0]),
    .rd_entry (rd_entry)
  );

  eev_match u_match (
    .entry         (rd_entry),
    .kind          (ev_kind),
    .site          (ev_site),
    .target_dec    (ev_target),
    .cont_fragment (ev_cont),
    .result        (m)
  );

  // scan finishes on the first hit, or once all limit entries have been read
  assign issue     = ptr < limit;
  assign scan_done = (rd_vld && m.hit) || (!issue && !rd_vld);

  always_comb begin
    state_next = state;
    case (state)
      eev_pkg::ST_IDLE: begin
        if (in_acc) begin
          if ((req_type == eev_pkg::REQ_WRITE) || (event_version != expected_version) ||
              (exit_kind == eev_pkg::KIND_FAULT)) begin
            state_next = eev_pkg::ST_DONE;
          end else begin
            state_next = eev_pkg::ST_SCAN;
          end
        end
      end
      eev_pkg::ST_SCAN: begin
        if (scan_done) begin
          state_next = eev_pkg::ST_DONE;
        end
      end
      eev_pkg::ST_DONE: begin
        if (out_load) begin
          state_next = eev_pkg::ST_IDLE;
        end
      end
      default: state_next = eev_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    rd_en    = 1'b0;
    scan_res = eev_pkg::FAULT_BAD_SITE;
    if (rd_vld && m.hit) begin
      scan_res = m.target_ok ? eev_pkg::FAULT_NONE : eev_pkg::FAULT_BAD_TARGET;
    end
    res_next = res;
    case (state)
      eev_pkg::ST_IDLE: begin
        if (req_type == eev_pkg::REQ_WRITE) begin
          res_next = eev_pkg::FAULT_NONE;
        end else if (event_version != expected_version) begin
          res_next = eev_pkg::FAULT_BAD_VERSION;
        end else if (exit_kind == eev_pkg::KIND_FAULT) begin
          res_next = eev_pkg::FAULT_BAD_KIND;
        end else begin
          res_next = eev_pkg::FAULT_NONE;
        end
      end
      eev_pkg::ST_SCAN: begin
        rd_en = issue && !(rd_vld && m.hit);
        if (scan_done) begin
          res_next = scan_res;
        end
      end
      default: res_next = res;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cookie           <= '0;
      expected_version <= 32'd1;
      exit_count       <= '0;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        eev_pkg::REG_COOKIE:     cookie           <= cfg_data;
        eev_pkg::REG_VERSION:    expected_version <= cfg_data[31:0];
        eev_pkg::REG_EXIT_COUNT: exit_count       <= cfg_data[4:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= eev_pkg::ST_IDLE;
      ptr    <= '0;
      rd_vld <= 1'b0;
    end else begin
      state <= state_next;
      if (in_acc) begin
        ptr    <= '0;
        rd_vld <= 1'b0;
      end else if (state == eev_pkg::ST_SCAN) begin
        if (issue) begin
          ptr <= ptr + CNT_W'(1);
        end
        rd_vld <= rd_en;
      end
    end
  end

  always_ff @(posedge clk) begin
    res <= res_next;
    if (in_acc) begin
      ev_kind   <= exit_kind;
      ev_site   <= site_id;
      ev_target <= tgt_dec;
      ev_cont   <= cont_dec[eev_pkg::HALF_W-1:0];
      limit     <= (count_ext > CNT_W'(MAX_EXITS)) ? CNT_W'(MAX_EXITS) : count_ext;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      fault <= res;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/eev_checker.sv =====
// Port-level checker for the exit event validator, bound to the top level.
`timescale 1ns / 1ps
`default_nettype none
`include "exit_event_validator_macros.svh"

module eev_checker (
  input wire logic                          clk,
  input wire logic                          rst,
  input wire logic                          in_valid,
  input wire logic                          in_stall,
  input wire logic                          out_valid,
  input wire logic                          out_stall,
  input wire logic [eev_pkg::FAULT_W-1:0]   fault
);

  // one item at a time: an accepted item blocks the input next cycle
  `EEV_ASSERT(a_busy_after_accept, clk, rst, (in_valid && !in_stall) |=> in_stall, "input taken while busy")

  // no stray result comes out of reset
  `EEV_ASSERT_ALWAYS(a_reset_empties, clk, rst |=> !out_valid, "result present after reset")

  `EEV_ASSERT(a_fault_code, clk, rst, out_valid |-> (fault <= eev_pkg::FAULT_BAD_SITE), "undefined fault code")

  `EEV_ASSERT(a_out_hold, clk, rst, (out_valid && out_stall) |=> (out_valid && $stable(fault)), "stalled result changed")

endmodule

bind exit_event_validator eev_checker u_eev_checker (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (in_valid),
  .in_stall  (in_stall),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .fault     (fault)
);

`default_nettype wire

// ===== sim/tb_exit_event_validator.sv =====
// Testbench for exit_event_validator: table writes and exit checks against an in-bench predictor.
`timescale 1ns / 1ps

module tb_exit_event_validator;

  localparam int MAX_EXITS    = 16;
  localparam int SITE_POOL_N  = 8;
  localparam int DRAIN_CYCLES = 24;
  localparam int LONG_HOLD    = 300;
  localparam logic [eev_pkg::CFG_IDX_W-1:0] REG_UNUSED = 2'd3;
  localparam logic [eev_pkg::KIND_W-1:0] KIND_PLAIN_FIRST = 3'd4;
  localparam logic [eev_pkg::KIND_W-1:0] KIND_PLAIN_LAST  = 3'd7;

  typedef logic [eev_pkg::KIND_W-1:0] kind_t;
  typedef logic [3:0] index_t;

  typedef struct packed {
    logic                        req_type;
    logic [3:0]                  entry_index;
    logic [31:0]                 event_version;
    logic [eev_pkg::KIND_W-1:0]  exit_kind;
    logic [31:0]                 site_id;
    logic [eev_pkg::TOKEN_W-1:0] tgt_token;
    logic [eev_pkg::TOKEN_W-1:0] cont_token;
    logic [31:0]                 target_fragment;
    logic [31:0]                 target_function;
    logic [31:0]                 continuation_fragment;
  } request_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  logic                          cfg_wr_en = 1'b0;
  logic [eev_pkg::CFG_IDX_W-1:0] cfg_index = '0;
  logic [eev_pkg::TOKEN_W-1:0]   cfg_data = '0;

  logic                        in_valid = 1'b0;
  logic                        in_stall;
  logic                        req_type = 1'b0;
  logic [3:0]                  entry_index = '0;
  logic [31:0]                 event_version = '0;
  logic [eev_pkg::KIND_W-1:0]  exit_kind = '0;
  logic [31:0]                 site_id = '0;
  logic [eev_pkg::TOKEN_W-1:0] tgt_token = '0;
  logic [eev_pkg::TOKEN_W-1:0] cont_token = '0;
  logic [31:0]                 entry_target_fragment = '0;
  logic [31:0]                 entry_target_function = '0;
  logic [31:0]                 entry_continuation_fragment = '0;
  logic                        out_valid;
  logic                        out_stall = 1'b0;
  logic [eev_pkg::FAULT_W-1:0] fault;

  // register copies seen by the predictor
  logic [eev_pkg::TOKEN_W-1:0] cookie_reg = '0;
  logic [31:0]                 version_reg = 32'd1;
  logic [4:0]                  count_reg = '0;

  // table as the block holds it after each accepted item
  logic [31:0]                tab_site [MAX_EXITS];
  logic [eev_pkg::KIND_W-1:0] tab_kind [MAX_EXITS];
  logic [31:0]                tab_frag [MAX_EXITS];
  logic [31:0]                tab_func [MAX_EXITS];
  logic [31:0]                tab_cont [MAX_EXITS];

  // table as it will be once every queued request has gone in
  logic [31:0]                plan_site [MAX_EXITS];
  logic [eev_pkg::KIND_W-1:0] plan_kind [MAX_EXITS];
  logic [31:0]                plan_frag [MAX_EXITS];
  logic [31:0]                plan_func [MAX_EXITS];
  logic [31:0]                plan_cont [MAX_EXITS];

  logic [31:0] site_pool [SITE_POOL_N];

  request_t                    queued_requests[$];
  logic [eev_pkg::FAULT_W-1:0] faults_due[$];
  request_t                    offered_req;

  int send_idle_pct = 7;
  int recv_idle_pct = 76;
  logic hold_send = 1'b0;
  logic hold_go = 1'b0;
  int hold_count = 0;
  int mismatch_count = 0;

  exit_event_validator #(
    .MAX_EXITS(MAX_EXITS)
  ) u_dut (
    .clk(clk),
    .rst(rst),
    .cfg_wr_en(cfg_wr_en),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .req_type(req_type),
    .entry_index(entry_index),
    .event_version(event_version),
    .exit_kind(exit_kind),
    .site_id(site_id),
    .tgt_token(tgt_token),
    .cont_token(cont_token),
    .entry_target_fragment(entry_target_fragment),
    .entry_target_function(entry_target_function),
    .entry_continuation_fragment(entry_continuation_fragment),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .fault(fault)
  );

  always #2 clk = ~clk;

  function automatic logic [eev_pkg::TOKEN_W-1:0] unseal(logic [eev_pkg::TOKEN_W-1:0] t);
    return {t[eev_pkg::ROT_BITS-1:0], t[eev_pkg::TOKEN_W-1:eev_pkg::ROT_BITS]} ^ cookie_reg;
  endfunction

  function automatic logic [eev_pkg::TOKEN_W-1:0] seal(logic [eev_pkg::TOKEN_W-1:0] v);
    logic [eev_pkg::TOKEN_W-1:0] raw;
    raw = v ^ cookie_reg;
    return {raw[eev_pkg::TOKEN_W-eev_pkg::ROT_BITS-1:0],
            raw[eev_pkg::TOKEN_W-1:eev_pkg::TOKEN_W-eev_pkg::ROT_BITS]};
  endfunction

  function automatic logic [eev_pkg::TOKEN_W-1:0] rand64();
    return {$urandom, $urandom};
  endfunction

  // Applies one accepted item to the table copy and returns its fault code.
  function automatic logic [eev_pkg::FAULT_W-1:0] judge_exit(request_t r);
    logic [eev_pkg::TOKEN_W-1:0] tgt;
    logic [eev_pkg::TOKEN_W-1:0] cnt;
    int lim;
    if (r.req_type == eev_pkg::REQ_WRITE) begin
      tab_site[r.entry_index] = r.site_id;
      tab_kind[r.entry_index] = r.exit_kind;
      tab_frag[r.entry_index] = r.target_fragment;
      tab_func[r.entry_index] = r.target_function;
      tab_cont[r.entry_index] = r.continuation_fragment;
      return eev_pkg::FAULT_NONE;
    end
    if (r.event_version != version_reg) return eev_pkg::FAULT_BAD_VERSION;
    if (r.exit_kind == eev_pkg::KIND_FAULT) return eev_pkg::FAULT_BAD_KIND;
    tgt = unseal(r.tgt_token);
    cnt = unseal(r.cont_token);
    lim = (count_reg > MAX_EXITS) ? MAX_EXITS : int'(count_reg);
    for (int i = 0; i < lim; i++) begin
      if (tab_site[i] == r.site_id && tab_kind[i] == r.exit_kind) begin
        if (r.exit_kind == eev_pkg::KIND_NEXT && tgt[eev_pkg::HALF_W-1:0] != tab_frag[i])
          return eev_pkg::FAULT_BAD_TARGET;
        if ((r.exit_kind == eev_pkg::KIND_CALL || r.exit_kind == eev_pkg::KIND_TAIL) &&
            (tgt[eev_pkg::TOKEN_W-1:eev_pkg::HALF_W] != tab_func[i] ||
             tgt[eev_pkg::HALF_W-1:0] != '0))
          return eev_pkg::FAULT_BAD_TARGET;
        if (r.exit_kind == eev_pkg::KIND_CALL && cnt[eev_pkg::HALF_W-1:0] != tab_cont[i])
          return eev_pkg::FAULT_BAD_TARGET;
        return eev_pkg::FAULT_NONE;
      end
    end
    return eev_pkg::FAULT_BAD_SITE;
  endfunction

  function automatic request_t entry_req(logic [3:0] idx, logic [31:0] site,
                                         logic [eev_pkg::KIND_W-1:0] kind,
                                         logic [31:0] frag, logic [31:0] func,
                                         logic [31:0] cont);
    request_t r;
    r.req_type = eev_pkg::REQ_WRITE;
    r.entry_index = idx;
    r.event_version = $urandom;
    r.exit_kind = kind;
    r.site_id = site;
    r.tgt_token = rand64();
    r.cont_token = rand64();
    r.target_fragment = frag;
    r.target_function = func;
    r.continuation_fragment = cont;
    plan_site[idx] = site;
    plan_kind[idx] = kind;
    plan_frag[idx] = frag;
    plan_func[idx] = func;
    plan_cont[idx] = cont;
    return r;
  endfunction

  // Exit event with the current version; tgt/cont are decoded values.
  function automatic request_t event_req(logic [eev_pkg::KIND_W-1:0] kind, logic [31:0] site,
                                         logic [eev_pkg::TOKEN_W-1:0] tgt,
                                         logic [eev_pkg::TOKEN_W-1:0] cont);
    request_t r;
    r.req_type = eev_pkg::REQ_CHECK;
    r.entry_index = index_t'($urandom);
    r.event_version = version_reg;
    r.exit_kind = kind;
    r.site_id = site;
    r.tgt_token = seal(tgt);
    r.cont_token = seal(cont);
    r.target_fragment = $urandom;
    r.target_function = $urandom;
    r.continuation_fragment = $urandom;
    return r;
  endfunction

  function automatic request_t draw_request();
    request_t r;
    logic [eev_pkg::TOKEN_W-1:0] tv;
    logic [eev_pkg::TOKEN_W-1:0] cv;
    logic [eev_pkg::KIND_W-1:0] k;
    int pick;
    int j;
    int b;
    pick = $urandom_range(99);
    if (pick < 12) begin
      k = ($urandom_range(9) == 0) ? eev_pkg::KIND_FAULT :
          kind_t'($urandom_range(KIND_PLAIN_LAST, eev_pkg::KIND_NEXT));
      r = entry_req(index_t'($urandom), site_pool[$urandom_range(SITE_POOL_N-1)], k,
                    $urandom, $urandom, $urandom);
    end else if (pick < 88) begin
      // aimed at one entry, mostly well formed
      j = $urandom_range(MAX_EXITS-1);
      tv = {plan_func[j], $urandom};
      if (plan_kind[j] == eev_pkg::KIND_CALL || plan_kind[j] == eev_pkg::KIND_TAIL)
        tv[eev_pkg::HALF_W-1:0] = '0;
      else tv[eev_pkg::HALF_W-1:0] = plan_frag[j];
      cv = {$urandom, plan_cont[j]};
      if ($urandom_range(3) == 0) begin
        b = $urandom_range(eev_pkg::TOKEN_W-1);
        if ($urandom_range(1) == 0) tv[b] = ~tv[b];
        else cv[b] = ~cv[b];
      end
      r = event_req(plan_kind[j], plan_site[j], tv, cv);
      if ($urandom_range(19) == 0) r.event_version = $urandom;
    end else begin
      r = event_req(kind_t'($urandom), $urandom, rand64(), rand64());
      r.tgt_token = rand64();
      r.cont_token = rand64();
      if ($urandom_range(1) == 0) r.event_version = $urandom;
      if ($urandom_range(1) == 0) r.site_id = site_pool[$urandom_range(SITE_POOL_N-1)];
    end
    return r;
  endfunction

  task automatic flag_mismatch(string msg);
    $display("MISMATCH at %0t ns: %s", $time, msg);
    mismatch_count++;
  endtask

  task automatic enqueue(request_t r);
    queued_requests.insert(queued_requests.size(), r);
  endtask

  task automatic cfg_write(logic [eev_pkg::CFG_IDX_W-1:0] idx,
                           logic [eev_pkg::TOKEN_W-1:0] data);
    @(posedge clk);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    case (idx)
      eev_pkg::REG_COOKIE:     cookie_reg = data;
      eev_pkg::REG_VERSION:    version_reg = data[31:0];
      eev_pkg::REG_EXIT_COUNT: count_reg = data[4:0];
      default: ;
    endcase
    @(posedge clk);
    cfg_wr_en <= 1'b0;
  endtask

  task automatic wait_idle();
    @(negedge clk);
    while (queued_requests.size() != 0 || in_valid || faults_due.size() != 0)
      @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  task automatic push_random(int n);
    repeat (n) enqueue(draw_request());
  endtask

  task automatic run_phase(logic [eev_pkg::TOKEN_W-1:0] ck, logic [31:0] ver,
                           logic [4:0] cnt, int n);
    wait_idle();
    cfg_write(eev_pkg::REG_COOKIE, ck);
    cfg_write(eev_pkg::REG_VERSION, {32'h0, ver});
    cfg_write(eev_pkg::REG_EXIT_COUNT, {59'h0, cnt});
    @(negedge clk);
    push_random(n);
  endtask

  // sender: holds a stalled item, otherwise offers the next one or idles
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall)
        faults_due.insert(faults_due.size(), judge_exit(offered_req));
      if (!(in_valid && in_stall)) begin
        if (queued_requests.size() != 0 && !hold_send &&
            $urandom_range(99) >= send_idle_pct) begin
          offered_req = queued_requests.pop_front();
          in_valid <= 1'b1;
          req_type <= offered_req.req_type;
          entry_index <= offered_req.entry_index;
          event_version <= offered_req.event_version;
          exit_kind <= offered_req.exit_kind;
          site_id <= offered_req.site_id;
          tgt_token <= offered_req.tgt_token;
          cont_token <= offered_req.cont_token;
          entry_target_fragment <= offered_req.target_fragment;
          entry_target_function <= offered_req.target_function;
          entry_continuation_fragment <= offered_req.continuation_fragment;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // receiver: compares each taken result with the oldest fault due
  always @(posedge clk) begin
    logic [eev_pkg::FAULT_W-1:0] want;
    if (rst) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        if (faults_due.size() == 0) begin
          flag_mismatch($sformatf("result fault=%0d with no item outstanding", fault));
        end else begin
          want = faults_due.pop_front();
          if (fault !== want)
            flag_mismatch($sformatf("fault got %0d want %0d", fault, want));
        end
      end
      out_stall <= (hold_count != 0) || ($urandom_range(99) < recv_idle_pct);
    end
  end

  // long receiver hold-off
  always @(posedge clk) begin
    if (rst) hold_count <= 0;
    else if (hold_go && hold_count == 0) hold_count <= LONG_HOLD;
    else if (hold_count != 0) hold_count <= hold_count - 1;
  end

  initial begin
    #2_000_000;
    $display("** exit_event_validator: FAILED **");
    $finish;
  end

  initial begin
    logic [31:0] stray_site;
    site_pool[0] = '0;
    site_pool[1] = '1;
    for (int i = 2; i < SITE_POOL_N; i++) site_pool[i] = $urandom;
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // reset settings: count 0, every entry filled before any scan can read it
    for (int i = 0; i < MAX_EXITS; i++) begin
      case (i)
        0: enqueue(entry_req(index_t'(i), '0, eev_pkg::KIND_NEXT, '0, '0, '0));
        1: enqueue(entry_req(index_t'(i), '1, eev_pkg::KIND_CALL, '1, '1, '1));
        2: enqueue(entry_req(index_t'(i), site_pool[2], eev_pkg::KIND_TAIL,
                             $urandom, $urandom, $urandom));
        3: enqueue(entry_req(index_t'(i), site_pool[3], KIND_PLAIN_LAST,
                             $urandom, $urandom, $urandom));
        4: enqueue(entry_req(index_t'(i), site_pool[3], eev_pkg::KIND_NEXT,
                             $urandom, $urandom, $urandom));
        5: enqueue(entry_req(index_t'(i), site_pool[3], eev_pkg::KIND_NEXT,
                             plan_frag[4] ^ 32'h1, $urandom, $urandom));
        6: enqueue(entry_req(index_t'(i), site_pool[4], eev_pkg::KIND_FAULT,
                             $urandom, $urandom, $urandom));
        default: enqueue(entry_req(index_t'(i), site_pool[$urandom_range(SITE_POOL_N-1)],
                                   kind_t'($urandom_range(KIND_PLAIN_LAST,
                                                          eev_pkg::KIND_NEXT)),
                                   $urandom, $urandom, $urandom));
      endcase
    end
    enqueue(event_req(eev_pkg::KIND_NEXT, '0, '0, '0));
    queued_requests[$].event_version = '0;
    enqueue(event_req(KIND_PLAIN_FIRST, '0, '0, '0));

    run_phase(rand64(), '1, 5'd16, 0);
    stray_site = $urandom;
    for (int i = 0; i < SITE_POOL_N; i++)
      if (stray_site == site_pool[i]) stray_site = ~stray_site;
    enqueue(event_req(eev_pkg::KIND_NEXT, '0, {$urandom, 32'h0}, rand64()));
    enqueue(event_req(eev_pkg::KIND_NEXT, '0, {$urandom, 32'h1}, rand64()));
    enqueue(event_req(eev_pkg::KIND_CALL, '1, {32'hFFFF_FFFF, 32'h0},
                      {$urandom, 32'hFFFF_FFFF}));
    enqueue(event_req(eev_pkg::KIND_CALL, '1, {32'hFFFF_FFFF, 32'h0},
                      {$urandom, 32'hFFFF_FFFE}));
    enqueue(event_req(eev_pkg::KIND_CALL, '1, {32'hFFFF_FFFF, 32'h1},
                      {$urandom, 32'hFFFF_FFFF}));
    enqueue(event_req(eev_pkg::KIND_TAIL, site_pool[2], {plan_func[2], 32'h0}, rand64()));
    enqueue(event_req(eev_pkg::KIND_TAIL, site_pool[2], {~plan_func[2], 32'h0}, rand64()));
    enqueue(event_req(KIND_PLAIN_LAST, site_pool[3], rand64(), rand64()));
    // same site and kind twice: the earlier entry decides
    enqueue(event_req(eev_pkg::KIND_NEXT, site_pool[3], {$urandom, plan_frag[5]}, rand64()));
    enqueue(event_req(eev_pkg::KIND_NEXT, site_pool[3], {$urandom, plan_frag[4]}, rand64()));
    enqueue(event_req(KIND_PLAIN_FIRST, stray_site, rand64(), rand64()));
    enqueue(event_req(eev_pkg::KIND_FAULT, site_pool[4], rand64(), rand64()));
    enqueue(event_req(eev_pkg::KIND_NEXT, '0, '0, '0));
    queued_requests[$].event_version = ~version_reg;

    run_phase('1, '0, 5'd16, 120);
    @(negedge clk);
    hold_go = 1'b1;
    @(negedge clk);
    hold_go = 1'b0;
    while (hold_count != 0) @(negedge clk);

    run_phase(rand64(), $urandom, 5'd1, 110);
    wait_idle();
    cfg_write(REG_UNUSED, rand64());

    wait_idle();
    send_idle_pct = 76;
    recv_idle_pct = 7;
    run_phase('0, 32'd1, 5'd7, 60);
    @(negedge clk);
    hold_send = 1'b1;
    while (in_valid || faults_due.size() != 0) @(negedge clk);
    hold_send = 1'b0;
    push_random(60);
    run_phase(rand64(), $urandom, 5'($urandom_range(MAX_EXITS)), 110);

    wait_idle();
    send_idle_pct = 0;
    recv_idle_pct = 0;
    run_phase(rand64(), '1, 5'd16, 120);
    run_phase(rand64(), $urandom, 5'd0, 60);
    run_phase(rand64(), 32'd5, 5'd12, 60);
    wait_idle();

    if (mismatch_count == 0) begin
      $display("** exit_event_validator: PASSED **");
    end else begin
      $display("** exit_event_validator: FAILED **");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
+incdir+rtl
rtl/eev_pkg.sv
rtl/eev_table.sv
rtl/eev_match.sv
rtl/exit_event_validator.sv
rtl/eev_checker.sv
sim/tb_exit_event_validator.sv
